@@ src/deadlock_cycle_detector_macros.svh @@
// assertion macros used by the checker file
`ifndef DEADLOCK_CYCLE_DETECTOR_MACROS_SVH
`define DEADLOCK_CYCLE_DETECTOR_MACROS_SVH

// consequence holds in the same cycle as the antecedent
`define DDC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequence holds in the cycle after the antecedent
`define DDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/ddc_pkg.sv @@
// ----------------------------------------------------------------------------
// ddc_pkg
// Shared constants, codes and control/status types of the deadlock detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ddc_pkg;

   localparam int VERTICES_DEF = 16;
   localparam int ID_W         = 32;
   localparam int KEY_W        = ID_W + 1;
   localparam int MODE_W       = 2;
   localparam int STATUS_W     = 2;
   localparam int VFIELD_W     = 4;
   localparam int EOP_W        = 3;

   typedef logic [MODE_W-1:0]   mode_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [EOP_W-1:0]    edge_op_type;

   localparam mode_type MODE_WAIT  = 2'd0;
   localparam mode_type MODE_GRANT = 2'd1;
   localparam mode_type MODE_POST  = 2'd2;
   localparam mode_type MODE_NONE  = 2'd3;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_DEADLOCK  = 2'd1;
   localparam status_type ST_FULL      = 2'd2;
   localparam status_type ST_NOT_FOUND = 2'd3;

   localparam edge_op_type EOP_NONE    = 3'd0;
   localparam edge_op_type EOP_REQ_SET = 3'd1;
   localparam edge_op_type EOP_REQ_CLR = 3'd2;
   localparam edge_op_type EOP_GRANT   = 3'd3;
   localparam edge_op_type EOP_POST    = 3'd4;

   typedef struct packed {
      logic        start;
      logic        scan;
      logic        ins_thread;
      logic        ins_res;
      logic        search_init;
      logic        search;
      logic        set_status;
      status_type  status;
      edge_op_type edge_op;
      logic        load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic     scan_done;
      mode_type mode;
      logic     t_found;
      logic     r_found;
      logic     fits;
      logic     hit;
      logic     stable;
   } dp_stat_type;

endpackage

@@ src/ddc_chan_if.sv @@
// ----------------------------------------------------------------------------
// ddc_chan_if
// Valid/ready channels for request events and detector responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ddc_req_if;
   import ddc_pkg::*;

   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [ID_W-1:0]     thread_id;
   logic [ID_W-1:0]     resource_id;

   modport source (output valid, mode, thread_id, resource_id, input ready);
   modport sink   (input valid, mode, thread_id, resource_id, output ready);
endinterface

interface ddc_rsp_if;
   import ddc_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [VFIELD_W-1:0] thread_vertex;
   logic [VFIELD_W-1:0] resource_vertex;

   modport source (output valid, status, thread_vertex, resource_vertex, input ready);
   modport sink   (input valid, status, thread_vertex, resource_vertex, output ready);
endinterface

@@ src/deadlock_cycle_detector.sv @@
// ----------------------------------------------------------------------------
// deadlock_cycle_detector: one event at a time, the next taken only once the last response is loaded
// wait: scan, insert new keys, search, edge update; grant, post: scan, edge update; mode three: response only
// reset (synchronous): empty key table, cleared edge matrix, no response pending
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deadlock_cycle_detector #(
   parameter int VERTICES = ddc_pkg::VERTICES_DEF
) (
   input logic       clock,
   input logic       reset,
   ddc_req_if.sink   req_chan,
   ddc_rsp_if.source rsp_chan
);
   import ddc_pkg::*;

   ctl_cmd_type cmd;
   dp_stat_type stat;

   ddc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_mode  (req_chan.mode),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ddc_datapath #(
      .VERTICES (VERTICES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_mode            (req_chan.mode),
      .req_thread_id       (req_chan.thread_id),
      .req_resource_id     (req_chan.resource_id),
      .rsp_status          (rsp_chan.status),
      .rsp_thread_vertex   (rsp_chan.thread_vertex),
      .rsp_resource_vertex (rsp_chan.resource_vertex)
   );
endmodule

@@ src/ddc_ram.sv @@
// ----------------------------------------------------------------------------
// ddc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ src/ddc_ctrl.sv @@
// ----------------------------------------------------------------------------
// ddc_ctrl
// Sequencer: lookup scan, key insertion, reachability search, edge update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  ddc_pkg::mode_type     req_mode,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  ddc_pkg::dp_stat_type  stat,
   output ddc_pkg::ctl_cmd_type  cmd
);
   import ddc_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_INS_T  = 3'd3;
   localparam logic [2:0] S_INS_R  = 3'd4;
   localparam logic [2:0] S_PREP   = 3'd5;
   localparam logic [2:0] S_SEARCH = 3'd6;
   localparam logic [2:0] S_FINISH = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = (req_mode == MODE_NONE) ? S_FINISH : S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_FINISH;
            case (stat.mode) inside
               MODE_WAIT: begin
                  if (!stat.fits) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_FULL;
                  end else if (!stat.t_found) begin
                     state_in = S_INS_T;
                  end else if (!stat.r_found) begin
                     state_in = S_INS_R;
                  end else begin
                     state_in = S_PREP;
                  end
               end
               MODE_GRANT, MODE_POST: begin
                  if (!(stat.t_found && stat.r_found)) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_NOT_FOUND;
                  end else begin
                     cmd.edge_op = (stat.mode == MODE_GRANT) ? EOP_GRANT : EOP_POST;
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_INS_T: begin
            cmd.ins_thread = 1'b1;
            state_in       = stat.r_found ? S_PREP : S_INS_R;
         end
         S_INS_R: begin
            cmd.ins_res = 1'b1;
            state_in    = S_PREP;
         end
         S_PREP: begin
            cmd.search_init = 1'b1;
            state_in        = S_SEARCH;
         end
         S_SEARCH: begin
            if (stat.hit) begin
               // thread reachable from resource: refuse the request edge
               cmd.edge_op    = EOP_REQ_CLR;
               cmd.set_status = 1'b1;
               cmd.status     = ST_DEADLOCK;
               state_in       = S_FINISH;
            end else if (stat.stable) begin
               cmd.edge_op = EOP_REQ_SET;
               state_in    = S_FINISH;
            end else begin
               cmd.search = 1'b1;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule

@@ src/ddc_datapath.sv @@
// ----------------------------------------------------------------------------
// ddc_datapath
// Vertex key table, adjacency matrix, frontier register and response fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddc_datapath #(
   parameter int VERTICES = ddc_pkg::VERTICES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ddc_pkg::ctl_cmd_type           cmd,
   output ddc_pkg::dp_stat_type           stat,
   input  ddc_pkg::mode_type              req_mode,
   input  logic [ddc_pkg::ID_W-1:0]       req_thread_id,
   input  logic [ddc_pkg::ID_W-1:0]       req_resource_id,
   output ddc_pkg::status_type            rsp_status,
   output logic [ddc_pkg::VFIELD_W-1:0]   rsp_thread_vertex,
   output logic [ddc_pkg::VFIELD_W-1:0]   rsp_resource_vertex
);
   import ddc_pkg::*;

   localparam int VW = $clog2(VERTICES);
   localparam int CW = $clog2(VERTICES + 1);

   mode_type             mode_ff;
   logic [ID_W-1:0]      tid_ff, rid_ff;
   logic                 t_found_ff, r_found_ff;
   logic [VW-1:0]        t_idx_ff, r_idx_ff;
   logic [CW-1:0]        count_ff, scan_ptr_ff;
   logic                 rd_pend_ff;
   logic [VW-1:0]        rd_idx_ff;
   logic [VERTICES-1:0]  reach_ff, reach_in;
   logic [VERTICES-1:0]  edge_ff [VERTICES];
   status_type           status_ff, rsp_status_ff;
   logic [VFIELD_W-1:0]  rsp_tv_ff, rsp_rv_ff;

   logic                 ram_we;
   logic [VW-1:0]        ram_waddr, ram_raddr;
   logic [KEY_W-1:0]     ram_wdata, ram_rdata;
   logic [KEY_W-1:0]     tkey, rkey;
   logic                 scan_more, t_hit, r_hit;
   logic [CW:0]          need_sum;

   assign tkey      = {1'b0, tid_ff};
   assign rkey      = {1'b1, rid_ff};
   assign scan_more = scan_ptr_ff < count_ff;
   assign ram_raddr = scan_ptr_ff[VW-1:0];
   assign ram_we    = cmd.ins_thread || cmd.ins_res;
   assign ram_waddr = count_ff[VW-1:0];
   assign ram_wdata = cmd.ins_thread ? tkey : rkey;
   assign t_hit     = rd_pend_ff && (ram_rdata == tkey);
   assign r_hit     = rd_pend_ff && (ram_rdata == rkey);
   assign need_sum  = {1'b0, count_ff} + (CW+1)'(!t_found_ff) + (CW+1)'(!r_found_ff);

   ddc_ram #(
      .WIDTH (KEY_W),
      .DEPTH (VERTICES)
   ) u_keys (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // one frontier expansion: union of the rows of every reached vertex
   always_comb begin
      reach_in = reach_ff;
      for (int v = 0; v < VERTICES; v++) begin
         if (reach_ff[v]) begin
            reach_in = reach_in | edge_ff[v];
         end
      end
   end

   always_comb begin
      stat.scan_done = !scan_more && !rd_pend_ff;
      stat.mode      = mode_ff;
      stat.t_found   = t_found_ff;
      stat.r_found   = r_found_ff;
      stat.fits      = need_sum <= (CW+1)'(VERTICES);
      stat.hit       = reach_ff[t_idx_ff];
      stat.stable    = (reach_in == reach_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_found_ff  <= 1'b0;
         r_found_ff  <= 1'b0;
         count_ff    <= '0;
         scan_ptr_ff <= '0;
         rd_pend_ff  <= 1'b0;
         for (int i = 0; i < VERTICES; i++) begin
            edge_ff[i] <= '0;
         end
      end else begin
         if (cmd.start) begin
            mode_ff     <= req_mode;
            tid_ff      <= req_thread_id;
            rid_ff      <= req_resource_id;
            t_found_ff  <= 1'b0;
            r_found_ff  <= 1'b0;
            scan_ptr_ff <= '0;
            rd_pend_ff  <= 1'b0;
            status_ff   <= ST_OK;
         end
         if (cmd.scan) begin
            rd_pend_ff <= scan_more;
            rd_idx_ff  <= ram_raddr;
            if (scan_more) begin
               scan_ptr_ff <= scan_ptr_ff + 1'b1;
            end
            if (t_hit && !t_found_ff) begin
               t_found_ff <= 1'b1;
               t_idx_ff   <= rd_idx_ff;
            end
            if (r_hit && !r_found_ff) begin
               r_found_ff <= 1'b1;
               r_idx_ff   <= rd_idx_ff;
            end
         end
         if (cmd.ins_thread) begin
            t_found_ff <= 1'b1;
            t_idx_ff   <= count_ff[VW-1:0];
            count_ff   <= count_ff + 1'b1;
         end
         if (cmd.ins_res) begin
            r_found_ff <= 1'b1;
            r_idx_ff   <= count_ff[VW-1:0];
            count_ff   <= count_ff + 1'b1;
         end
         if (cmd.search_init) begin
            reach_ff <= {{(VERTICES-1){1'b0}}, 1'b1} << r_idx_ff;
         end
         if (cmd.search) begin
            reach_ff <= reach_in;
         end
         if (cmd.set_status) begin
            status_ff <= cmd.status;
         end
         case (cmd.edge_op)
            EOP_REQ_SET: edge_ff[t_idx_ff][r_idx_ff] <= 1'b1;
            EOP_REQ_CLR: edge_ff[t_idx_ff][r_idx_ff] <= 1'b0;
            EOP_GRANT: begin
               edge_ff[t_idx_ff][r_idx_ff] <= 1'b0;
               edge_ff[r_idx_ff][t_idx_ff] <= 1'b1;
            end
            EOP_POST:    edge_ff[r_idx_ff][t_idx_ff] <= 1'b0;
            default: begin
            end
         endcase
      end
   end

   // response fields: payload only, loaded on the transfer into the output slot
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_tv_ff     <= t_found_ff ? VFIELD_W'(t_idx_ff) : '0;
         rsp_rv_ff     <= r_found_ff ? VFIELD_W'(r_idx_ff) : '0;
      end
   end

   assign rsp_status          = rsp_status_ff;
   assign rsp_thread_vertex   = rsp_tv_ff;
   assign rsp_resource_vertex = rsp_rv_ff;
endmodule

@@ src/ddc_checker.sv @@
// ----------------------------------------------------------------------------
// ddc_checker
// Port-level checks of the detector handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "deadlock_cycle_detector_macros.svh"

module ddc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);
   // a pending response stays until its transfer
   `DDC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped")
   // reset leaves the block idle with no response
   `DDC_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && req_ready, "bad reset")
   // the block works on one event at a time
   `DDC_ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready, !req_ready, "not busy")
   // a new response appears only as the sequencer returns to idle
   `DDC_ASSERT_SAME(a_rsp_idle, clock, reset, $rose(rsp_valid), req_ready, "rsp not idle")
endmodule

bind deadlock_cycle_detector ddc_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready)
);
